// ===== hw/rtl/tirb_pkg.sv =====
// tirb_pkg: shared types, address map and mode bit positions for the
// timer and interrupt register block
// no dependencies

package tirb_pkg;

   // number of timers fitted (1 to 4) and the width of a timer index
   localparam int TIMER_COUNT = 4;
   localparam int TIMER_IDX_W = 2;

   // operation codes carried in tuser
   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } tirb_op_type;

   // fixed register addresses
   localparam logic [31:0] ADDR_IRQ_STATUS   = 32'h1000_F000;
   localparam logic [31:0] ADDR_IRQ_ENABLE   = 32'h1000_F010;
   localparam logic [31:0] ADDR_DMA_CONTROL  = 32'h1000_E000;
   localparam logic [31:0] ADDR_DMA_STATUS   = 32'h1000_E010;
   localparam logic [31:0] ADDR_DMA_PRIORITY = 32'h1000_E020;
   localparam logic [31:0] ADDR_MBOX_MAIN    = 32'h1000_F220;
   localparam logic [31:0] ADDR_MBOX_SUB     = 32'h1000_F230;

   // timer windows: 0x40 bytes each, 0x800 apart from the base
   localparam logic [31:0] TIMER_BASE = 32'h1000_0000;
   localparam logic [5:0]  OFS_COUNT   = 6'h00;
   localparam logic [5:0]  OFS_MODE    = 6'h10;
   localparam logic [5:0]  OFS_COMPARE = 6'h20;
   localparam logic [5:0]  OFS_HOLD    = 6'h30;

   // mode register bit positions
   localparam int MODE_ZRET = 6;
   localparam int MODE_CUE  = 7;
   localparam int MODE_CMPE = 8;
   localparam int MODE_OVFE = 9;
   localparam int MODE_EQUF = 10;
   localparam int MODE_OVFF = 11;

   // irq_status bit of timer 0
   localparam int IRQ_TIMER_BIT0 = 9;

   // one register access or tick as held in the input stage
   typedef struct packed {
      tirb_op_type op;
      logic [31:0] addr;
      logic [31:0] wdata;
      logic [15:0] ticks;
   } tirb_access_type;

   // per-timer command from the decoder
   typedef struct packed {
      logic        tick;
      logic [15:0] ticks;
      logic        wr_count;
      logic        wr_mode;
      logic        wr_compare;
      logic        wr_hold;
      logic [31:0] wdata;
   } tirb_timer_cmd_type;

   // per-timer registers and interrupt request back to the decoder
   typedef struct packed {
      logic [15:0] count;
      logic [31:0] mode;
      logic [15:0] compare;
      logic [15:0] hold;
      logic        irq_hit;
   } tirb_timer_state_type;

endpackage

// ===== hw/rtl/tirb_timer.sv =====
// tirb_timer: one 16-bit timer with count, mode, compare and hold registers
// depends on tirb_pkg

module tirb_timer
   import tirb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  tirb_timer_cmd_type   cmd,
   output tirb_timer_state_type state
);

   logic [15:0] count_ff, count_in;
   logic [31:0] mode_ff, mode_in;
   logic [15:0] compare_ff, compare_in;
   logic [15:0] hold_ff, hold_in;
   logic        irq_hit;

   // tick arithmetic and register writes
   always_comb begin
      logic [16:0] sum;
      logic        match;
      logic        ovf;
      sum        = {1'b0, count_ff} + {1'b0, cmd.ticks};
      match      = mode_ff[MODE_CMPE] && (compare_ff != 16'd0) &&
                   (count_ff < compare_ff) && (sum[15:0] >= compare_ff);
      ovf        = mode_ff[MODE_OVFE] && sum[16];
      count_in   = count_ff;
      mode_in    = mode_ff;
      compare_in = compare_ff;
      hold_in    = hold_ff;
      irq_hit    = 1'b0;
      if (cmd.tick && mode_ff[MODE_CUE]) begin
         count_in = (match && mode_ff[MODE_ZRET]) ? 16'd0 : sum[15:0];
         if (match) mode_in[MODE_EQUF] = 1'b1;
         if (ovf) mode_in[MODE_OVFF] = 1'b1;
         irq_hit = match || ovf;
      end
      if (cmd.wr_count) count_in = cmd.wdata[15:0];
      if (cmd.wr_mode) begin
         mode_in = cmd.wdata;
         mode_in[MODE_EQUF] = 1'b0;
         mode_in[MODE_OVFF] = 1'b0;
      end
      if (cmd.wr_compare) compare_in = cmd.wdata[15:0];
      if (cmd.wr_hold) hold_in = cmd.wdata[15:0];
   end

   // timer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         mode_ff    <= '0;
         compare_ff <= '0;
         hold_ff    <= '0;
      end else begin
         count_ff   <= count_in;
         mode_ff    <= mode_in;
         compare_ff <= compare_in;
         hold_ff    <= hold_in;
      end
   end

   assign state.count   = count_ff;
   assign state.mode    = mode_ff;
   assign state.compare = compare_ff;
   assign state.hold    = hold_ff;
   assign state.irq_hit = irq_hit;

`ifndef NO_ASSERTIONS
   // a mode write always leaves both sticky flags clear
   assert property (@(posedge clock) disable iff (reset)
      cmd.wr_mode |=> (mode_ff[MODE_EQUF] == 1'b0) && (mode_ff[MODE_OVFF] == 1'b0))
      else $error("timer mode write kept a sticky flag");

   // the count only moves on a write or an enabled tick
   assert property (@(posedge clock) disable iff (reset)
      (!cmd.wr_count && !(cmd.tick && mode_ff[MODE_CUE])) |=> $stable(count_ff))
      else $error("timer count moved without cause");
`endif

endmodule

// ===== hw/rtl/tirb_regs.sv =====
// tirb_regs: address decode, interrupt, dma and mailbox registers,
// the timer bank and the read mux
// depends on tirb_pkg and tirb_timer

module tirb_regs
   import tirb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  tirb_access_type acc,
   output logic [31:0]     read_data
);

   logic [31:0] irq_status_ff, irq_status_in;
   logic [31:0] irq_enable_ff, irq_enable_in;
   logic [31:0] dma_control_ff, dma_control_in;
   logic [31:0] dma_status_ff, dma_status_in;
   logic [31:0] dma_priority_ff, dma_priority_in;
   logic [31:0] mbox_main_ff, mbox_main_in;
   logic [31:0] mbox_sub_ff, mbox_sub_in;

   logic                 do_write;
   logic                 do_read;
   logic                 do_tick;
   logic [TIMER_COUNT-1:0] win_hit;
   tirb_timer_cmd_type   tmr_cmd [TIMER_COUNT];
   tirb_timer_state_type tmr_state [TIMER_COUNT];

   assign do_write = fire && (acc.op == OP_WRITE);
   assign do_read  = (acc.op == OP_READ);
   assign do_tick  = fire && (acc.op == OP_TICK);

   // timer windows and their commands
   for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_timer
      assign win_hit[i] = (acc.addr[31:13] == TIMER_BASE[31:13]) &&
                          (acc.addr[12:11] == TIMER_IDX_W'(i)) &&
                          (acc.addr[10:6] == 5'd0);

      always_comb begin
         tmr_cmd[i].tick       = do_tick;
         tmr_cmd[i].ticks      = acc.ticks;
         tmr_cmd[i].wr_count   = do_write && win_hit[i] && (acc.addr[5:0] == OFS_COUNT);
         tmr_cmd[i].wr_mode    = do_write && win_hit[i] && (acc.addr[5:0] == OFS_MODE);
         tmr_cmd[i].wr_compare = do_write && win_hit[i] && (acc.addr[5:0] == OFS_COMPARE);
         tmr_cmd[i].wr_hold    = do_write && win_hit[i] && (acc.addr[5:0] == OFS_HOLD);
         tmr_cmd[i].wdata      = acc.wdata;
      end

      tirb_timer u_timer (
         .clock (clock),
         .reset (reset),
         .cmd   (tmr_cmd[i]),
         .state (tmr_state[i])
      );
   end

   // next values of the fixed registers
   always_comb begin
      irq_status_in   = irq_status_ff;
      irq_enable_in   = irq_enable_ff;
      dma_control_in  = dma_control_ff;
      dma_status_in   = dma_status_ff;
      dma_priority_in = dma_priority_ff;
      mbox_main_in    = mbox_main_ff;
      mbox_sub_in     = mbox_sub_ff;
      if (do_write) begin
         case (acc.addr)
            ADDR_IRQ_STATUS:   irq_status_in   = irq_status_ff & ~acc.wdata;
            ADDR_IRQ_ENABLE:   irq_enable_in   = irq_enable_ff ^ acc.wdata;
            ADDR_DMA_CONTROL:  dma_control_in  = acc.wdata;
            ADDR_DMA_STATUS:   dma_status_in   = acc.wdata;
            ADDR_DMA_PRIORITY: dma_priority_in = acc.wdata;
            ADDR_MBOX_MAIN:    mbox_main_in    = acc.wdata;
            ADDR_MBOX_SUB:     mbox_sub_in     = acc.wdata;
            default: ;
         endcase
      end
      // timer events raise their status bits
      for (int i = 0; i < TIMER_COUNT; i++) begin
         if (tmr_state[i].irq_hit) irq_status_in[IRQ_TIMER_BIT0 + i] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_status_ff   <= '0;
         irq_enable_ff   <= '0;
         dma_control_ff  <= '0;
         dma_status_ff   <= '0;
         dma_priority_ff <= '0;
         mbox_main_ff    <= '0;
         mbox_sub_ff     <= '0;
      end else if (fire) begin
         irq_status_ff   <= irq_status_in;
         irq_enable_ff   <= irq_enable_in;
         dma_control_ff  <= dma_control_in;
         dma_status_ff   <= dma_status_in;
         dma_priority_ff <= dma_priority_in;
         mbox_main_ff    <= mbox_main_in;
         mbox_sub_ff     <= mbox_sub_in;
      end
   end

   // read mux, zero for unmapped addresses and for writes, ticks and no-ops
   always_comb begin
      read_data = '0;
      if (do_read) begin
         case (acc.addr)
            ADDR_IRQ_STATUS:   read_data = irq_status_ff;
            ADDR_IRQ_ENABLE:   read_data = irq_enable_ff;
            ADDR_DMA_CONTROL:  read_data = dma_control_ff;
            ADDR_DMA_STATUS:   read_data = dma_status_ff;
            ADDR_DMA_PRIORITY: read_data = dma_priority_ff;
            ADDR_MBOX_MAIN:    read_data = mbox_main_ff;
            ADDR_MBOX_SUB:     read_data = mbox_sub_ff;
            default: begin
               for (int i = 0; i < TIMER_COUNT; i++) begin
                  if (win_hit[i]) begin
                     case (acc.addr[5:0])
                        OFS_COUNT:   read_data = {16'd0, tmr_state[i].count};
                        OFS_MODE:    read_data = tmr_state[i].mode;
                        OFS_COMPARE: read_data = {16'd0, tmr_state[i].compare};
                        OFS_HOLD:    read_data = {16'd0, tmr_state[i].hold};
                        default:     read_data = '0;
                     endcase
                  end
               end
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   // a status write clears every bit written as one (no tick in the same beat)
   assert property (@(posedge clock) disable iff (reset)
      (do_write && (acc.addr == ADDR_IRQ_STATUS)) |=>
         ((irq_status_ff & $past(acc.wdata)) == 32'd0))
      else $error("irq status bits not cleared by write");
`endif

endmodule

// ===== hw/rtl/timer_interrupt_register_block_core.sv =====
// timer_interrupt_register_block_core: top level with input stage,
// register block and result register
// depends on tirb_pkg and tirb_regs
// flow: an accepted beat is held in the input stage, then its read data is registered in the result register
// throughput: one beat per cycle; while a result waits the input stage takes
// one more beat, then req_tready stays low until the result is taken
// reset: synchronous, active high; valid flags, registers and timers return
// to zero, the input and result data stages are not reset

module timer_interrupt_register_block_core
   import tirb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // address[31:0], write_data[63:32], tick_amount[79:64]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // read_data[31:0]
);

   logic            s1_valid_ff, s1_valid_in;
   tirb_access_type s1_acc_ff, s1_acc_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     rsp_data_ff, rsp_data_in;
   logic            advance;
   logic            fire;
   logic            req_accept;
   logic [31:0]     read_data;

   // stage handshake
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // input stage
   always_comb begin
      s1_valid_in     = s1_valid_ff;
      s1_acc_in       = s1_acc_ff;
      if (advance) s1_valid_in = 1'b0;
      if (req_accept) begin
         s1_valid_in     = 1'b1;
         s1_acc_in.op    = tirb_op_type'(req_tuser);
         s1_acc_in.addr  = req_tdata[31:0];
         s1_acc_in.wdata = req_tdata[63:32];
         s1_acc_in.ticks = req_tdata[79:64];
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = read_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_acc_ff   <= s1_acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   tirb_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .acc       (s1_acc_ff),
      .read_data (read_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a new result only appears behind a full input stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared with empty input stage");
`endif

endmodule

// ===== test/tirb_register_checker.sv =====
// tirb_register_checker: watches both stream channels of the timer and interrupt
// register block, predicts read data for every request beat and compares responses
// depends on tirb_pkg

module tirb_register_checker
   import tirb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,   // address[31:0], write_data[63:32], tick_amount[79:64]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // read_data[31:0]
   output int          mismatches,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] TIMER_STRIDE = 32'h0000_0800;
   localparam logic [31:0] TIMER_WINDOW = 32'h0000_0040;

   // predicted register contents
   logic [31:0] int_status;
   logic [31:0] int_mask;
   logic [31:0] dma_ctrl;
   logic [31:0] dma_stat;
   logic [31:0] dma_prio;
   logic [31:0] mbox_main;
   logic [31:0] mbox_sub;
   logic [15:0] tmr_count [TIMER_COUNT];
   logic [31:0] tmr_mode  [TIMER_COUNT];
   logic [15:0] tmr_cmp   [TIMER_COUNT];
   logic [15:0] tmr_hold  [TIMER_COUNT];

   // read data still owed by the block, oldest first
   logic [31:0] read_data_due [$];
   int          mismatch_count = 0;
   int          due_count = 0;

   assign mismatches = mismatch_count;
   assign pending    = due_count;

   // index of the fitted timer whose window holds the address, or -1
   function automatic int find_timer(input logic [31:0] addr, output logic [31:0] ofs);
      logic [31:0] base;
      ofs = '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
         base = TIMER_BASE + 32'(i) * TIMER_STRIDE;
         if (addr >= base && (addr - base) < TIMER_WINDOW) begin
            ofs = addr - base;
            return i;
         end
      end
      return -1;
   endfunction

   function automatic logic [31:0] read_register(input logic [31:0] addr);
      logic [31:0] ofs;
      int          t;
      case (addr)
         ADDR_IRQ_STATUS:   return int_status;
         ADDR_IRQ_ENABLE:   return int_mask;
         ADDR_DMA_CONTROL:  return dma_ctrl;
         ADDR_DMA_STATUS:   return dma_stat;
         ADDR_DMA_PRIORITY: return dma_prio;
         ADDR_MBOX_MAIN:    return mbox_main;
         ADDR_MBOX_SUB:     return mbox_sub;
         default: begin
            t = find_timer(addr, ofs);
            if (t < 0) return '0;
            // offset inside the window is below 0x40
            case (ofs[5:0])
               OFS_COUNT:   return {16'h0, tmr_count[t]};
               OFS_MODE:    return tmr_mode[t];
               OFS_COMPARE: return {16'h0, tmr_cmp[t]};
               OFS_HOLD:    return {16'h0, tmr_hold[t]};
               default:     return '0;
            endcase
         end
      endcase
   endfunction

   function automatic void write_register(input logic [31:0] addr, input logic [31:0] wdata);
      logic [31:0] ofs;
      logic [31:0] mode;
      int          t;
      case (addr)
         // status clears on ones, mask toggles on ones
         ADDR_IRQ_STATUS:   int_status = int_status & ~wdata;
         ADDR_IRQ_ENABLE:   int_mask   = int_mask ^ wdata;
         ADDR_DMA_CONTROL:  dma_ctrl   = wdata;
         ADDR_DMA_STATUS:   dma_stat   = wdata;
         ADDR_DMA_PRIORITY: dma_prio   = wdata;
         ADDR_MBOX_MAIN:    mbox_main  = wdata;
         ADDR_MBOX_SUB:     mbox_sub   = wdata;
         default: begin
            t = find_timer(addr, ofs);
            if (t >= 0) begin
               case (ofs[5:0])
                  OFS_COUNT:   tmr_count[t] = wdata[15:0];
                  OFS_MODE: begin
                     // sticky flags never survive a mode write
                     mode = wdata;
                     mode[MODE_EQUF] = 1'b0;
                     mode[MODE_OVFF] = 1'b0;
                     tmr_mode[t] = mode;
                  end
                  OFS_COMPARE: tmr_cmp[t]  = wdata[15:0];
                  OFS_HOLD:    tmr_hold[t] = wdata[15:0];
                  default: ;
               endcase
            end
         end
      endcase
   endfunction

   function automatic void advance_timers(input logic [15:0] ticks);
      logic [31:0] mode;
      logic [16:0] sum;
      logic [15:0] prev;
      logic [15:0] next;
      logic        hit;
      for (int i = 0; i < TIMER_COUNT; i++) begin
         mode = tmr_mode[i];
         if (mode[MODE_CUE]) begin
            prev = tmr_count[i];
            sum  = {1'b0, prev} + {1'b0, ticks};
            next = sum[15:0];
            hit  = 1'b0;
            // compare match: crossing upwards onto or past a nonzero target
            if (mode[MODE_CMPE] && tmr_cmp[i] != 16'h0 && prev < tmr_cmp[i]
                && next >= tmr_cmp[i]) begin
               mode[MODE_EQUF] = 1'b1;
               hit = 1'b1;
               if (mode[MODE_ZRET]) next = 16'h0;
            end
            // carry out of 16 bits
            if (mode[MODE_OVFE] && sum[16]) begin
               mode[MODE_OVFF] = 1'b1;
               hit = 1'b1;
            end
            tmr_mode[i]  = mode;
            tmr_count[i] = next;
            if (hit) int_status[IRQ_TIMER_BIT0 + i] = 1'b1;
         end
      end
   endfunction

   // read data that one request beat gives, updating the predicted state
   function automatic logic [31:0] predict_read_data(input tirb_op_type op,
                                                     input logic [31:0] addr,
                                                     input logic [31:0] wdata,
                                                     input logic [15:0] ticks);
      case (op)
         OP_READ:  return read_register(addr);
         OP_WRITE: write_register(addr, wdata);
         OP_TICK:  advance_timers(ticks);
         default: ;
      endcase
      return '0;
   endfunction

   // sample both channels at the rising edge
   always @(posedge clock) begin
      logic [31:0] due;
      if (reset) begin
         int_status = '0;
         int_mask   = '0;
         dma_ctrl   = '0;
         dma_stat   = '0;
         dma_prio   = '0;
         mbox_main  = '0;
         mbox_sub   = '0;
         for (int i = 0; i < TIMER_COUNT; i++) begin
            tmr_count[i] = '0;
            tmr_mode[i]  = '0;
            tmr_cmp[i]   = '0;
            tmr_hold[i]  = '0;
         end
         read_data_due.delete();
      end else begin
         if (req_tvalid && req_tready)
            read_data_due.push_back(predict_read_data(tirb_op_type'(req_tuser),
                                                      req_tdata[31:0], req_tdata[63:32],
                                                      req_tdata[79:64]));
         if (rsp_tvalid && rsp_tready) begin
            if (read_data_due.size() == 0) begin
               $display("%0t: response beat with nothing due, actual read_data %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               due = read_data_due.pop_front();
               if (rsp_tdata !== due) begin
                  $display("%0t: read_data expected %h actual %h", $time, due, rsp_tdata);
                  mismatch_count++;
               end
            end
         end
      end
      due_count = read_data_due.size();
   end

endmodule

// ===== test/tb.sv =====
// tb: stimulus and verdict for timer_interrupt_register_block_core
// depends on tirb_pkg, the core and tirb_register_checker

module tb
   import tirb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] TIMER_STRIDE = 32'h0000_0800;
   localparam int          RANDOM_BEATS = 1600;
   localparam int          QUIET_BEATS  = 200;
   localparam int          STALL_LIMIT  = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;   // address[31:0], write_data[63:32], tick_amount[79:64]
   logic [1:0]  req_tuser;   // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;   // read_data[31:0]

   logic        req_idling   = 1'b0;
   logic        rsp_stalling = 1'b0;
   int          rsp_hold_left = 0;
   int          mismatches;
   int          pending;
   int          quiet_cycles = 0;

   always #5 clock = ~clock;

   timer_interrupt_register_block_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   tirb_register_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // response back-pressure in random bursts, started while rsp_stalling is set
   always @(posedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_tready    <= 1'b0;
      end else if (rsp_stalling && $urandom_range(0, 5) == 0) begin
         rsp_hold_left <= $urandom_range(0, 4);
         rsp_tready    <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles with no beat on either channel
   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   // one request beat, with an optional idle gap ahead of it
   task automatic send_beat(input tirb_op_type op, input logic [31:0] addr,
                            input logic [31:0] wdata, input logic [15:0] ticks);
      if (req_idling && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ticks, wdata, addr};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // mostly mapped registers, some odd window offsets and stray addresses
   function automatic logic [31:0] pick_address();
      case ($urandom_range(0, 9))
         0: return ADDR_IRQ_STATUS;
         1: return ADDR_IRQ_ENABLE;
         2: case ($urandom_range(0, 2))
               0: return ADDR_DMA_CONTROL;
               1: return ADDR_DMA_STATUS;
               default: return ADDR_DMA_PRIORITY;
            endcase
         3: return $urandom_range(0, 1) ? ADDR_MBOX_MAIN : ADDR_MBOX_SUB;
         8: return TIMER_BASE + 32'($urandom_range(0, TIMER_COUNT)) * TIMER_STRIDE
                   + 32'($urandom_range(0, 63));
         9: return $urandom;
         default: return TIMER_BASE + 32'($urandom_range(0, TIMER_COUNT - 1)) * TIMER_STRIDE
                         + 32'($urandom_range(0, 3) * 16);
      endcase
   endfunction

   initial begin
      tirb_op_type op;
      logic [31:0] addr;
      logic [31:0] wdata;
      logic [15:0] ticks;
      int          k;

      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_NONE;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, mask toggle, match with zero-return, overflow
      send_beat(OP_READ,  ADDR_IRQ_STATUS, 32'h0, 16'h0);
      send_beat(OP_WRITE, ADDR_IRQ_ENABLE, 32'hFFFF_FFFF, 16'h0);
      send_beat(OP_READ,  ADDR_IRQ_ENABLE, 32'h0, 16'h0);
      send_beat(OP_WRITE, TIMER_BASE + 32'(OFS_MODE), 32'hFFFF_FFFF, 16'h0);
      send_beat(OP_WRITE, TIMER_BASE + 32'(OFS_COMPARE), 32'hFFFF_0010, 16'h0);
      send_beat(OP_TICK,  32'h0, 32'h0, 16'h0010);
      send_beat(OP_READ,  TIMER_BASE + 32'(OFS_MODE), 32'h0, 16'h0);
      send_beat(OP_WRITE, TIMER_BASE + 32'(OFS_COUNT), 32'hFFFF_FFFF, 16'h0);
      send_beat(OP_TICK,  32'h0, 32'h0, 16'hFFFF);
      send_beat(OP_READ,  TIMER_BASE + 32'(OFS_COUNT), 32'h0, 16'h0);
      send_beat(OP_READ,  TIMER_BASE + 32'(OFS_MODE), 32'h0, 16'h0);
      send_beat(OP_READ,  ADDR_IRQ_STATUS, 32'h0, 16'h0);
      send_beat(OP_WRITE, ADDR_IRQ_STATUS, 32'hFFFF_FFFF, 16'h0);
      send_beat(OP_TICK,  32'h0, 32'h0, 16'h0);
      send_beat(OP_READ,  ADDR_IRQ_STATUS, 32'h0, 16'h0);
      send_beat(OP_WRITE, ADDR_MBOX_MAIN, 32'hFFFF_FFFF, 16'h0);
      send_beat(OP_READ,  ADDR_MBOX_MAIN, 32'h0, 16'h0);
      // hold of the last timer, a gap inside its window, a window past the last timer
      addr = TIMER_BASE + 32'(TIMER_COUNT - 1) * TIMER_STRIDE;
      send_beat(OP_WRITE, addr + 32'(OFS_HOLD), 32'hFFFF_FFFF, 16'h0);
      send_beat(OP_READ,  addr + 32'(OFS_HOLD), 32'h0, 16'h0);
      send_beat(OP_READ,  addr + 32'h3C, 32'h0, 16'h0);
      addr = TIMER_BASE + 32'(TIMER_COUNT) * TIMER_STRIDE;
      send_beat(OP_WRITE, addr + 32'(OFS_MODE), 32'hFFFF_FFFF, 16'h0);
      send_beat(OP_READ,  addr + 32'(OFS_MODE), 32'h0, 16'h0);
      send_beat(OP_READ,  32'hFFFF_FFFF, 32'h0, 16'h0);
      send_beat(OP_READ,  TIMER_BASE - 32'h1, 32'h0, 16'h0);
      send_beat(OP_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);

      // random traffic; idling switched per stretch, none at the tail
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 100 == 0) begin
            req_idling   <= (n < RANDOM_BEATS - QUIET_BEATS) && ($urandom_range(0, 2) != 0);
            rsp_stalling <= (n < RANDOM_BEATS - QUIET_BEATS) && ($urandom_range(0, 2) != 0);
         end
         k = $urandom_range(0, 19);
         if (k < 8)       op = OP_READ;
         else if (k < 15) op = OP_WRITE;
         else if (k < 19) op = OP_TICK;
         else             op = OP_NONE;
         addr  = pick_address();
         wdata = $urandom;
         // mode writes mostly enable counting and events
         if (addr[5:0] == OFS_MODE) begin
            if ($urandom_range(0, 3) != 0) wdata[MODE_CUE]  = 1'b1;
            if ($urandom_range(0, 2) != 0) wdata[MODE_CMPE] = 1'b1;
            if ($urandom_range(0, 2) != 0) wdata[MODE_OVFE] = 1'b1;
         end else if ($urandom_range(0, 1) == 0) begin
            wdata[15:0] = 16'($urandom_range(0, 16'h0800));
         end else if ($urandom_range(0, 3) == 0) begin
            wdata[15:0] = 16'($urandom_range(16'hFF00, 16'hFFFF));
         end
         case ($urandom_range(0, 7))
            0: ticks = 16'($urandom_range(0, 16'hFFFF));
            1: ticks = 16'hFFFF;
            2: ticks = 16'h0;
            default: ticks = 16'($urandom_range(1, 300));
         endcase
         send_beat(op, addr, wdata, ticks);
      end
      req_tvalid <= 1'b0;

      // drain, then let the pipeline settle
      do @(negedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/tirb_pkg.sv
hw/rtl/tirb_timer.sv
hw/rtl/tirb_regs.sv
hw/rtl/timer_interrupt_register_block_core.sv
test/tirb_register_checker.sv
test/tb.sv
